// ===== rtl/core/sia_pkg.sv =====
// Shared constants and controller/datapath interface types for the decimal text converter.
package sia_pkg;

    localparam int INPUT_BITS = 32;
    localparam int NDIG       = (INPUT_BITS * 1233) / 4096 + 1;
    localparam int BCD_W      = 4 * NDIG;
    localparam int CNT_W      = $clog2(INPUT_BITS);
    localparam int DCNT_W     = $clog2(NDIG + 1);

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ     = 4'd3;

    typedef struct packed {
        logic load;
        logic conv;
        logic shift;
    } t_cmd;

    typedef struct packed {
        logic negative;
        logic top_zero;
    } t_sts;

endpackage

// ===== rtl/core/sia_datapath.sv =====
// Datapath: magnitude load, shift-add-3 binary to BCD conversion, digit output.
module sia_datapath
    import sia_pkg::*;
(
    input  logic                         i_clk,
    input  logic signed [INPUT_BITS-1:0] i_value,
    input  t_cmd                         i_cmd,
    input  logic                         i_sel_minus,
    output t_sts                         o_sts,
    output logic [7:0]                   o_character
);

    logic [INPUT_BITS-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic                  r_neg, n_neg;
    logic [BCD_W-1:0]      adj;
    logic [3:0]            top;

    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[4*d +: 4] >= BCD_ADJ_MIN) begin
                adj[4*d +: 4] = r_bcd[4*d +: 4] + BCD_ADJ;
            end else begin
                adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        n_neg = r_neg;
        if (i_cmd.load) begin
            n_neg = i_value[INPUT_BITS-1];
            n_bin = i_value[INPUT_BITS-1] ? (~i_value + 1'b1) : i_value;
            n_bcd = '0;
        end else if (i_cmd.conv) begin
            n_bcd = {adj[BCD_W-2:0], r_bin[INPUT_BITS-1]};
            n_bin = {r_bin[INPUT_BITS-2:0], 1'b0};
        end else if (i_cmd.shift) begin
            n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_neg <= n_neg;
    end

    assign top            = r_bcd[BCD_W-1 -: 4];
    assign o_sts.negative = r_neg;
    assign o_sts.top_zero = (top == 4'd0);
    assign o_character    = i_sel_minus ? CHAR_MINUS : (CHAR_ZERO + {4'd0, top});

endmodule

// ===== rtl/core/sia_ctrl.sv =====
// Controller: sequences load, conversion steps, sign, leading-zero skip and digit output.
module sia_ctrl
    import sia_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output logic o_busy,
    output t_cmd o_cmd,
    output logic o_sel_minus,
    output logic o_strobe,
    output logic o_last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_SIGN = 3'd2;
    localparam logic [2:0] S_SKIP = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_bitcnt, n_bitcnt;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;

    always_comb begin
        n_state     = r_state;
        n_bitcnt    = r_bitcnt;
        n_dcnt      = r_dcnt;
        o_cmd       = '0;
        o_sel_minus = 1'b0;
        o_strobe    = 1'b0;
        o_last      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_bitcnt   = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                n_bitcnt   = r_bitcnt + 1'b1;
                if (r_bitcnt == CNT_W'(INPUT_BITS - 1)) begin
                    n_dcnt  = DCNT_W'(NDIG);
                    n_state = i_sts.negative ? S_SIGN : S_SKIP;
                end
            end
            S_SIGN: begin
                o_strobe    = 1'b1;
                o_sel_minus = 1'b1;
                n_state     = S_SKIP;
            end
            S_SKIP: begin
                if (i_sts.top_zero && (r_dcnt > DCNT_W'(1))) begin
                    o_cmd.shift = 1'b1;
                    n_dcnt      = r_dcnt - 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_strobe    = 1'b1;
                o_last      = (r_dcnt == DCNT_W'(1));
                o_cmd.shift = 1'b1;
                n_dcnt      = r_dcnt - 1'b1;
                if (r_dcnt == DCNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bitcnt <= '0;
            r_dcnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_bitcnt <= n_bitcnt;
            r_dcnt   <= n_dcnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// Top level: signed integer to decimal ASCII character stream.
// An item is taken when start is high while busy is low. After 32 shift-add-3
// steps in the BCD datapath, the controller gives a '-' for negative values,
// drops leading zeros one BCD digit position per cycle and then puts out one
// digit per cycle on o_character with o_strobe high, o_last marking the final
// digit. Each result is valid for exactly one cycle and cannot be held off.
// An item keeps the block busy through its 32 conversion steps, the leading-zero
// skip and the digit output over the 10 BCD digit positions, and the sign for a
// negative value; start may be raised again in the cycle busy falls.
module signed_int_to_decimal_ascii
    import sia_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [INPUT_BITS-1:0] i_value,
    output logic                         o_strobe,
    output logic [7:0]                   o_character,
    output logic                         o_last
);

    t_cmd cmd;
    t_sts sts;
    logic sel_minus;

    sia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_sts       (sts),
        .o_busy      (busy),
        .o_cmd       (cmd),
        .o_sel_minus (sel_minus),
        .o_strobe    (o_strobe),
        .o_last      (o_last)
    );

    sia_datapath u_dp (
        .i_clk       (i_clk),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .i_sel_minus (sel_minus),
        .o_sts       (sts),
        .o_character (o_character)
    );

endmodule

// ===== rtl/core/sia_checker.sv =====
// Port-level checker for the decimal text converter, bound to the top level.
module sia_checker
    import sia_pkg::*;
(
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic signed [INPUT_BITS-1:0] i_value,
    input logic                         o_strobe,
    input logic [7:0]                   o_character,
    input logic                         o_last
);

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while idle");

    a_accept_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_strobe))
        else $error("result right after item accept");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("result after last character");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_character == CHAR_MINUS && !o_last) ||
                      (o_character >= CHAR_ZERO && o_character <= CHAR_ZERO + 8'd9)))
        else $error("illegal output character");

    a_minus_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_value[INPUT_BITS-1]) |->
            ##33 (o_strobe && o_character == CHAR_MINUS))
        else $error("negative item without leading minus");

endmodule

bind signed_int_to_decimal_ascii sia_checker u_sia_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_value     (i_value),
    .o_strobe    (o_strobe),
    .o_character (o_character),
    .o_last      (o_last)
);

// ===== tb/signed_int_to_decimal_ascii_checker.sv =====
// Checker for the decimal text converter: predicts each number's characters and compares them.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_checker
    import sia_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [INPUT_BITS-1:0] i_value,
    input  logic                  i_strobe,
    input  logic [7:0]            i_character,
    input  logic                  i_last,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int MAX_DIGITS = 20;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_text_char;

    t_text_char expected_text [$];
    t_text_char want;
    int         fail_total;

    // Queue the expected characters of one number, most significant first.
    function automatic void push_decimal_text(input logic [INPUT_BITS-1:0] raw);
        logic [INPUT_BITS-1:0] magnitude;
        logic [3:0]            digits [MAX_DIGITS];
        int                    count;
        t_text_char            ch;
        magnitude = raw[INPUT_BITS-1] ? (~raw + 1'b1) : raw;
        count = 0;
        do begin
            digits[count] = 4'(magnitude % 10);
            magnitude     = magnitude / 10;
            count++;
        end while (magnitude != 0 && count < MAX_DIGITS);
        if (raw[INPUT_BITS-1]) begin
            ch.character = CHAR_MINUS;
            ch.last      = 1'b0;
            expected_text.push_back(ch);
        end
        for (int i = count - 1; i >= 0; i--) begin
            ch.character = 8'(CHAR_ZERO + digits[i]);
            ch.last      = (i == 0);
            expected_text.push_back(ch);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_text.delete();
        end else begin
            if (i_strobe) begin
                if (expected_text.size() == 0) begin
                    $error("character: expected none, got %0d", i_character);
                    fail_total++;
                end else begin
                    want = expected_text.pop_front();
                    if (i_character !== want.character) begin
                        $error("character: expected %0d, got %0d", want.character, i_character);
                        fail_total++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_last);
                        fail_total++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                push_decimal_text(i_value);
            end
        end
        o_pending    <= expected_text.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== tb/tb_signed_int_to_decimal_ascii.sv =====
// Testbench top for the decimal text converter: clock, reset, number stimulus and verdict.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii
    import sia_pkg::*;
();

    localparam int CYCLE_LIMIT     = 300000;
    localparam int ITEMS_PER_PHASE = 113;
    localparam int DRAIN_CYCLES    = 60;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic signed [INPUT_BITS-1:0] i_value;
    logic                         o_strobe;
    logic [7:0]                   o_character;
    logic                         o_last;

    int fail_count;
    int pending;
    int cycles;
    int idle_pct;

    logic [INPUT_BITS-1:0] corner_values [$];
    int                    phase_idle [4];

    signed_int_to_decimal_ascii dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

    signed_int_to_decimal_ascii_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_value      (i_value),
        .i_strobe     (o_strobe),
        .i_character  (o_character),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Hold start high until the item is taken; drop it only on idle cycles.
    task automatic send_value(input logic [INPUT_BITS-1:0] v);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain_text();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [INPUT_BITS-1:0] random_value();
        logic [INPUT_BITS-1:0] v;
        int                    k;
        int                    p;
        k = $urandom_range(1, 9);
        p = 10 ** k;
        case ($urandom_range(4))
            0, 1: v = $urandom;
            2: v = $urandom_range(0, p - 1);
            3: v = p + $urandom_range(0, 2) - 1;
            default: v = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                           : 32'h8000_0000 + $urandom_range(0, 3);
        endcase
        if (k < 10 && $urandom_range(1) && $urandom_range(4) inside {2, 3}) v = -v;
        else if ($urandom_range(1)) v = -v;
        return v;
    endfunction

    initial begin
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_value  = '0;
        idle_pct = 0;
        corner_values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                          -32'sd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                          32'd1000000000, 32'd999999999, -32'sd999999999,
                          -32'sd1000000000, 32'd1234567890, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'hFFFF_FFFE, 32'd7};
        phase_idle = '{0, 85, 18, 0};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_values[i]) begin
            send_value(corner_values[i]);
        end
        drain_text();

        foreach (phase_idle[p]) begin
            idle_pct = phase_idle[p];
            repeat (ITEMS_PER_PHASE) begin
                send_value(random_value());
            end
            drain_text();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/sia_pkg.sv
rtl/core/sia_datapath.sv
rtl/core/sia_ctrl.sv
rtl/core/signed_int_to_decimal_ascii.sv
rtl/core/sia_checker.sv
tb/signed_int_to_decimal_ascii_checker.sv
tb/tb_signed_int_to_decimal_ascii.sv
